@@ hdl/balu_pkg.sv @@
package balu_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        CMD_ADD_B     = 5'd0,
        CMD_ADC_B     = 5'd1,
        CMD_ADD_W     = 5'd2,
        CMD_ADC_W     = 5'd3,
        CMD_SUB_B     = 5'd4,
        CMD_SBC_B     = 5'd5,
        CMD_SBC_W     = 5'd6,
        CMD_AND       = 5'd7,
        CMD_OR        = 5'd8,
        CMD_XOR       = 5'd9,
        CMD_CP        = 5'd10,
        CMD_SLA       = 5'd11,
        CMD_SLL       = 5'd12,
        CMD_SRA       = 5'd13,
        CMD_SRL       = 5'd14,
        CMD_RL        = 5'd15,
        CMD_RLC       = 5'd16,
        CMD_RL_FULL   = 5'd17,
        CMD_RLC_FULL  = 5'd18,
        CMD_RR        = 5'd19,
        CMD_RRC       = 5'd20,
        CMD_RR_FULL   = 5'd21,
        CMD_RRC_FULL  = 5'd22,
        CMD_INC_B     = 5'd23,
        CMD_INC_W     = 5'd24,
        CMD_DEC_B     = 5'd25,
        CMD_DEC_W     = 5'd26,
        CMD_SET       = 5'd27,
        CMD_RES       = 5'd28,
        CMD_BIT       = 5'd29,
        CMD_NEG       = 5'd30,
        CMD_LOAD_FLAGS = 5'd31
    } cmd_t;

    // Flag bit positions
    localparam int FLAG_S  = 7;
    localparam int FLAG_Z  = 6;
    localparam int FLAG_H  = 4;
    localparam int FLAG_PV = 2;
    localparam int FLAG_N  = 1;
    localparam int FLAG_C  = 0;

    localparam logic [7:0] FLAG_LEGAL_MASK = 8'hD7;
    localparam logic [7:0] FLAG_KEEP_MASK  = 8'hC4;

    typedef struct packed {
        logic [15:0] res;
        logic [7:0]  flags;
    } alu_out_t;

endpackage

@@ hdl/byte_alu_with_flags_unit.sv @@
// The request lands in the input register at accept; the result register loads from
// it once the output side is free. Throughput: one request per cycle while the output
// is not stalled; the flag register is read and written in the single compute stage,
// so back-to-back requests see the flags of the one before.
// Reset: asynchronous, active low; clears both valid bits and the flag register.
module byte_alu_with_flags_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  cmd,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [2:0]  bit_or_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result,
    output logic [7:0]  flags_out
);

    logic                s1_valid_reg;
    balu_pkg::cmd_t      s1_cmd_reg;
    logic [15:0]         s1_a_reg;
    logic [15:0]         s1_b_reg;
    logic [2:0]          s1_n_reg;

    logic                out_valid_reg;
    logic [15:0]         result_reg;
    logic [7:0]          flags_out_reg;
    logic [7:0]          flag_reg;

    logic                advance;
    logic                in_take;
    balu_pkg::alu_out_t  alu_next;

    function automatic logic [7:0] sz_f(input logic [7:0] v);
        logic [7:0] f;
        f = 8'h00;
        f[balu_pkg::FLAG_S] = v[7];
        f[balu_pkg::FLAG_Z] = (v == 8'h00);
        return f;
    endfunction

    function automatic logic [7:0] szp_f(input logic [7:0] v);
        logic [7:0] f;
        f = sz_f(v);
        f[balu_pkg::FLAG_PV] = ~^v;
        return f;
    endfunction

    function automatic balu_pkg::alu_out_t arith8(input logic [7:0] a, input logic [7:0] b,
                                                  input logic cin, input logic sub);
        logic [8:0]         r9;
        logic [8:0]         cv;
        balu_pkg::alu_out_t o;
        if (sub)
            r9 = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        else
            r9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        cv = {1'b0, a} ^ {1'b0, b} ^ r9;
        o.res = {8'h00, r9[7:0]};
        o.flags = sz_f(r9[7:0]);
        o.flags[balu_pkg::FLAG_H]  = cv[4];
        o.flags[balu_pkg::FLAG_PV] = cv[8] ^ cv[7];
        o.flags[balu_pkg::FLAG_N]  = sub;
        o.flags[balu_pkg::FLAG_C]  = r9[8];
        return o;
    endfunction

    function automatic balu_pkg::alu_out_t arith16(input logic [15:0] a, input logic [15:0] b,
                                                   input logic cin, input logic sub);
        logic [16:0]        r17;
        logic [16:0]        cv;
        balu_pkg::alu_out_t o;
        if (sub)
            r17 = {1'b0, a} - {1'b0, b} - {16'h0000, cin};
        else
            r17 = {1'b0, a} + {1'b0, b} + {16'h0000, cin};
        cv = {1'b0, a} ^ {1'b0, b} ^ r17;
        o.res = r17[15:0];
        o.flags = 8'h00;
        o.flags[balu_pkg::FLAG_S]  = r17[15];
        o.flags[balu_pkg::FLAG_Z]  = (r17[15:0] == 16'h0000);
        o.flags[balu_pkg::FLAG_H]  = cv[12];
        o.flags[balu_pkg::FLAG_PV] = cv[16] ^ cv[15];
        o.flags[balu_pkg::FLAG_N]  = sub;
        o.flags[balu_pkg::FLAG_C]  = r17[16];
        return o;
    endfunction

    // Move the held request into the result register when that register frees up
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        logic [7:0]         a;
        logic [7:0]         b;
        logic [7:0]         mask;
        logic [7:0]         r;
        logic [7:0]         keep;
        logic               cy;
        balu_pkg::alu_out_t t;

        a    = s1_a_reg[7:0];
        b    = s1_b_reg[7:0];
        mask = 8'h01 << s1_n_reg;
        cy   = flag_reg[balu_pkg::FLAG_C];
        keep = flag_reg & balu_pkg::FLAG_KEEP_MASK;
        r    = 8'h00;
        t    = '0;
        alu_next.res   = 16'h0000;
        alu_next.flags = flag_reg;

        case (s1_cmd_reg)
            balu_pkg::CMD_ADD_B: alu_next = arith8(a, b, 1'b0, 1'b0);
            balu_pkg::CMD_ADC_B: alu_next = arith8(a, b, cy, 1'b0);
            balu_pkg::CMD_ADD_W:
            begin
                t = arith16(s1_a_reg, s1_b_reg, 1'b0, 1'b0);
                alu_next.res = t.res;
                alu_next.flags = keep;
                alu_next.flags[balu_pkg::FLAG_H] = t.flags[balu_pkg::FLAG_H];
                alu_next.flags[balu_pkg::FLAG_C] = t.flags[balu_pkg::FLAG_C];
            end
            balu_pkg::CMD_ADC_W: alu_next = arith16(s1_a_reg, s1_b_reg, cy, 1'b0);
            balu_pkg::CMD_SUB_B: alu_next = arith8(a, b, 1'b0, 1'b1);
            balu_pkg::CMD_SBC_B: alu_next = arith8(a, b, cy, 1'b1);
            balu_pkg::CMD_SBC_W: alu_next = arith16(s1_a_reg, s1_b_reg, cy, 1'b1);
            balu_pkg::CMD_AND:
            begin
                r = a & b;
                alu_next.res = {8'h00, r};
                alu_next.flags = szp_f(r);
                alu_next.flags[balu_pkg::FLAG_H] = 1'b1;
            end
            balu_pkg::CMD_OR:
            begin
                r = a | b;
                alu_next.res = {8'h00, r};
                alu_next.flags = szp_f(r);
            end
            balu_pkg::CMD_XOR:
            begin
                r = a ^ b;
                alu_next.res = {8'h00, r};
                alu_next.flags = szp_f(r);
            end
            balu_pkg::CMD_CP:
            begin
                t = arith8(a, b, 1'b0, 1'b1);
                alu_next.res = {8'h00, a};
                alu_next.flags = t.flags;
            end
            balu_pkg::CMD_SLA, balu_pkg::CMD_SLL:
            begin
                r = a << s1_n_reg;
                r[0] = (s1_cmd_reg == balu_pkg::CMD_SLL);
                alu_next.res = {8'h00, r};
                alu_next.flags = szp_f(r);
                alu_next.flags[balu_pkg::FLAG_C] = a[7];
            end
            balu_pkg::CMD_SRA, balu_pkg::CMD_SRL:
            begin
                r = a >> s1_n_reg;
                r[7] = (s1_cmd_reg == balu_pkg::CMD_SRA) ? a[7] : 1'b0;
                alu_next.res = {8'h00, r};
                alu_next.flags = szp_f(r);
                alu_next.flags[balu_pkg::FLAG_C] = a[0];
            end
            balu_pkg::CMD_RL, balu_pkg::CMD_RLC, balu_pkg::CMD_RL_FULL, balu_pkg::CMD_RLC_FULL:
            begin
                r = {a[6:0], ((s1_cmd_reg == balu_pkg::CMD_RL) ||
                              (s1_cmd_reg == balu_pkg::CMD_RL_FULL)) ? cy : a[7]};
                alu_next.res = {8'h00, r};
                if ((s1_cmd_reg == balu_pkg::CMD_RL) || (s1_cmd_reg == balu_pkg::CMD_RLC))
                    alu_next.flags = keep;
                else
                    alu_next.flags = szp_f(r);
                alu_next.flags[balu_pkg::FLAG_C] = a[7];
            end
            balu_pkg::CMD_RR, balu_pkg::CMD_RRC, balu_pkg::CMD_RR_FULL, balu_pkg::CMD_RRC_FULL:
            begin
                r = {((s1_cmd_reg == balu_pkg::CMD_RR) ||
                      (s1_cmd_reg == balu_pkg::CMD_RR_FULL)) ? cy : a[0], a[7:1]};
                alu_next.res = {8'h00, r};
                if ((s1_cmd_reg == balu_pkg::CMD_RR) || (s1_cmd_reg == balu_pkg::CMD_RRC))
                    alu_next.flags = keep;
                else
                    alu_next.flags = szp_f(r);
                alu_next.flags[balu_pkg::FLAG_C] = a[0];
            end
            balu_pkg::CMD_INC_B:
            begin
                r = a + 8'h01;
                alu_next.res = {8'h00, r};
                alu_next.flags = sz_f(r);
                alu_next.flags[balu_pkg::FLAG_C]  = cy;
                alu_next.flags[balu_pkg::FLAG_H]  = (a[3:0] == 4'hF);
                alu_next.flags[balu_pkg::FLAG_PV] = (a == 8'h7F);
            end
            balu_pkg::CMD_INC_W: alu_next.res = s1_a_reg + 16'h0001;
            balu_pkg::CMD_DEC_B:
            begin
                r = a - 8'h01;
                alu_next.res = {8'h00, r};
                alu_next.flags = sz_f(r);
                alu_next.flags[balu_pkg::FLAG_C]  = cy;
                alu_next.flags[balu_pkg::FLAG_N]  = 1'b1;
                alu_next.flags[balu_pkg::FLAG_H]  = (a[3:0] == 4'h0);
                alu_next.flags[balu_pkg::FLAG_PV] = (a == 8'h80);
            end
            balu_pkg::CMD_DEC_W: alu_next.res = s1_a_reg - 16'h0001;
            balu_pkg::CMD_SET:   alu_next.res = {8'h00, a | mask};
            balu_pkg::CMD_RES:   alu_next.res = {8'h00, a & ~mask};
            balu_pkg::CMD_BIT:
            begin
                alu_next.res = {8'h00, a};
                alu_next.flags = 8'h00;
                alu_next.flags[balu_pkg::FLAG_C] = cy;
                alu_next.flags[balu_pkg::FLAG_H] = 1'b1;
                alu_next.flags[balu_pkg::FLAG_Z] = ((a & mask) == 8'h00);
            end
            balu_pkg::CMD_NEG:
            begin
                r = 8'h00 - a;
                alu_next.res = {8'h00, r};
                alu_next.flags = sz_f(r);
                alu_next.flags[balu_pkg::FLAG_N]  = 1'b1;
                alu_next.flags[balu_pkg::FLAG_H]  = (a[3:0] != 4'h0);
                alu_next.flags[balu_pkg::FLAG_PV] = (a == 8'h80);
                alu_next.flags[balu_pkg::FLAG_C]  = (a != 8'h00);
            end
            balu_pkg::CMD_LOAD_FLAGS:
            begin
                alu_next.res = 16'h0000;
                alu_next.flags = b & balu_pkg::FLAG_LEGAL_MASK;
            end
            default:
            begin
                alu_next.res = 16'h0000;
                alu_next.flags = flag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= 8'h00;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flag_reg      <= alu_next.flags;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg <= balu_pkg::cmd_t'(cmd);
            s1_a_reg   <= operand_a;
            s1_b_reg   <= operand_b;
            s1_n_reg   <= bit_or_count;
        end
        if (advance)
        begin
            result_reg    <= alu_next.res;
            flags_out_reg <= alu_next.flags;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign flags_out = flags_out_reg;

    // The flag register always mirrors the flags of the last result issued
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flag_reg == flags_out_reg))
        else $error("flag register differs from issued flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((flags_out_reg[5] == 1'b0) && (flags_out_reg[3] == 1'b0)))
        else $error("reserved flag bits set");

    // A held request must not be overwritten while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_cmd_reg)
                                        && $stable(s1_a_reg) && $stable(s1_b_reg)))
        else $error("held request lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && s1_valid_reg) |-> advance)
        else $error("request accepted into a full stage");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 150000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [4:0]  cmd = '0;
    logic [15:0] operand_a = '0;
    logic [15:0] operand_b = '0;
    logic [2:0]  bit_or_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] result;
    logic [7:0]  flags_out;

    balu_pkg::alu_out_t predicted_results[$];
    logic [7:0]  flag_model = 8'h00;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 7;
    int          rx_idle_pct = 46;

    byte_alu_with_flags_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .bit_or_count (bit_or_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result),
        .flags_out    (flags_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // S and Z of a byte; szp_bits adds the parity flag, set on an even count of ones
    function automatic logic [7:0] sz_bits(input logic [7:0] v);
        logic [7:0] f;
        f = '0;
        f[balu_pkg::FLAG_S] = v[7];
        f[balu_pkg::FLAG_Z] = (v == 8'h00);
        return f;
    endfunction

    function automatic logic [7:0] szp_bits(input logic [7:0] v);
        logic [7:0] f;
        f = sz_bits(v);
        f[balu_pkg::FLAG_PV] = ~^v;
        return f;
    endfunction

    function automatic balu_pkg::alu_out_t alu_predict(input balu_pkg::cmd_t op,
                                                       input logic [15:0] wa,
                                                       input logic [15:0] wb,
                                                       input logic [2:0] n,
                                                       input logic [7:0] old);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic [7:0]  f;
        logic [7:0]  keep;
        logic [8:0]  r9;
        logic [8:0]  cv9;
        logic [16:0] r17;
        logic [16:0] cv17;
        logic [15:0] r;
        logic [15:0] sh;
        logic        cy;
        logic        cin;
        logic        sub;
        balu_pkg::alu_out_t o;
        a    = wa[7:0];
        b    = wb[7:0];
        cy   = old[balu_pkg::FLAG_C];
        keep = old & balu_pkg::FLAG_KEEP_MASK;
        f    = old;
        r    = '0;
        sh   = {8'h00, a} << n;
        case (op)
            balu_pkg::CMD_ADD_B, balu_pkg::CMD_ADC_B, balu_pkg::CMD_SUB_B,
            balu_pkg::CMD_SBC_B, balu_pkg::CMD_CP:
            begin
                cin = (op == balu_pkg::CMD_ADC_B || op == balu_pkg::CMD_SBC_B) ? cy : 1'b0;
                sub = (op == balu_pkg::CMD_SUB_B || op == balu_pkg::CMD_SBC_B ||
                       op == balu_pkg::CMD_CP);
                r9  = sub ? ({1'b0, a} - {1'b0, b} - {8'h00, cin})
                          : ({1'b0, a} + {1'b0, b} + {8'h00, cin});
                cv9 = {1'b0, a} ^ {1'b0, b} ^ r9;
                f = sz_bits(r9[7:0]);
                f[balu_pkg::FLAG_H]  = cv9[4];
                f[balu_pkg::FLAG_PV] = cv9[8] ^ cv9[7];
                f[balu_pkg::FLAG_N]  = sub;
                f[balu_pkg::FLAG_C]  = r9[8];
                r = (op == balu_pkg::CMD_CP) ? {8'h00, a} : {8'h00, r9[7:0]};
            end
            balu_pkg::CMD_ADD_W, balu_pkg::CMD_ADC_W, balu_pkg::CMD_SBC_W:
            begin
                cin  = (op == balu_pkg::CMD_ADD_W) ? 1'b0 : cy;
                sub  = (op == balu_pkg::CMD_SBC_W);
                r17  = sub ? ({1'b0, wa} - {1'b0, wb} - {16'h0000, cin})
                           : ({1'b0, wa} + {1'b0, wb} + {16'h0000, cin});
                // overflow needs the carry out of bit 15 (r17[16]) as well
                cv17 = {1'b0, wa} ^ {1'b0, wb} ^ r17;
                r = r17[15:0];
                if (op == balu_pkg::CMD_ADD_W)
                begin
                    f = keep;
                end
                else
                begin
                    f = '0;
                    f[balu_pkg::FLAG_S]  = r17[15];
                    f[balu_pkg::FLAG_Z]  = (r17[15:0] == 16'h0000);
                    f[balu_pkg::FLAG_PV] = cv17[16] ^ cv17[15];
                    f[balu_pkg::FLAG_N]  = sub;
                end
                f[balu_pkg::FLAG_H] = cv17[12];
                f[balu_pkg::FLAG_C] = r17[16];
            end
            balu_pkg::CMD_AND:
            begin
                r8 = a & b;
                f = szp_bits(r8);
                f[balu_pkg::FLAG_H] = 1'b1;
                r = {8'h00, r8};
            end
            balu_pkg::CMD_OR:
            begin
                r8 = a | b;
                f = szp_bits(r8);
                r = {8'h00, r8};
            end
            balu_pkg::CMD_XOR:
            begin
                r8 = a ^ b;
                f = szp_bits(r8);
                r = {8'h00, r8};
            end
            balu_pkg::CMD_SLA, balu_pkg::CMD_SLL, balu_pkg::CMD_SRA, balu_pkg::CMD_SRL:
            begin
                case (op)
                    balu_pkg::CMD_SLA: r8 = sh[7:0] & 8'hFE;
                    balu_pkg::CMD_SLL: r8 = sh[7:0] | 8'h01;
                    balu_pkg::CMD_SRA: r8 = (a >> n) | (a & 8'h80);
                    default:           r8 = (a >> n) & 8'h7F;
                endcase
                f = szp_bits(r8);
                f[balu_pkg::FLAG_C] = (op == balu_pkg::CMD_SLA || op == balu_pkg::CMD_SLL)
                                      ? a[7] : a[0];
                r = {8'h00, r8};
            end
            balu_pkg::CMD_RL, balu_pkg::CMD_RLC, balu_pkg::CMD_RL_FULL,
            balu_pkg::CMD_RLC_FULL, balu_pkg::CMD_RR, balu_pkg::CMD_RRC,
            balu_pkg::CMD_RR_FULL, balu_pkg::CMD_RRC_FULL:
            begin
                case (op)
                    balu_pkg::CMD_RL, balu_pkg::CMD_RL_FULL:   r8 = {a[6:0], cy};
                    balu_pkg::CMD_RLC, balu_pkg::CMD_RLC_FULL: r8 = {a[6:0], a[7]};
                    balu_pkg::CMD_RR, balu_pkg::CMD_RR_FULL:   r8 = {cy, a[7:1]};
                    default:                                   r8 = {a[0], a[7:1]};
                endcase
                if (op == balu_pkg::CMD_RL || op == balu_pkg::CMD_RLC ||
                    op == balu_pkg::CMD_RR || op == balu_pkg::CMD_RRC)
                    f = keep;
                else
                    f = szp_bits(r8);
                f[balu_pkg::FLAG_C] = (op == balu_pkg::CMD_RL || op == balu_pkg::CMD_RLC ||
                                       op == balu_pkg::CMD_RL_FULL ||
                                       op == balu_pkg::CMD_RLC_FULL) ? a[7] : a[0];
                r = {8'h00, r8};
            end
            balu_pkg::CMD_INC_B:
            begin
                r8 = a + 8'd1;
                f = sz_bits(r8);
                f[balu_pkg::FLAG_C]  = cy;
                f[balu_pkg::FLAG_H]  = (a[3:0] == 4'hF);
                f[balu_pkg::FLAG_PV] = (a == 8'h7F);
                r = {8'h00, r8};
            end
            balu_pkg::CMD_DEC_B:
            begin
                r8 = a - 8'd1;
                f = sz_bits(r8);
                f[balu_pkg::FLAG_C]  = cy;
                f[balu_pkg::FLAG_N]  = 1'b1;
                f[balu_pkg::FLAG_H]  = (a[3:0] == 4'h0);
                f[balu_pkg::FLAG_PV] = (a == 8'h80);
                r = {8'h00, r8};
            end
            balu_pkg::CMD_INC_W: r = wa + 16'd1;
            balu_pkg::CMD_DEC_W: r = wa - 16'd1;
            balu_pkg::CMD_SET:   r = {8'h00, a | (8'h01 << n)};
            balu_pkg::CMD_RES:   r = {8'h00, a & ~(8'h01 << n)};
            balu_pkg::CMD_BIT:
            begin
                r = {8'h00, a};
                f = '0;
                f[balu_pkg::FLAG_C] = cy;
                f[balu_pkg::FLAG_H] = 1'b1;
                f[balu_pkg::FLAG_Z] = ~a[n];
            end
            balu_pkg::CMD_NEG:
            begin
                r8 = 8'h00 - a;
                f = sz_bits(r8);
                f[balu_pkg::FLAG_N]  = 1'b1;
                f[balu_pkg::FLAG_H]  = (a[3:0] != 4'h0);
                f[balu_pkg::FLAG_PV] = (a == 8'h80);
                f[balu_pkg::FLAG_C]  = (a != 8'h00);
                r = {8'h00, r8};
            end
            default:
            begin
                r = '0;
                f = b & balu_pkg::FLAG_LEGAL_MASK;
            end
        endcase
        o.res   = r;
        o.flags = f;
        return o;
    endfunction

    task automatic send_request(input balu_pkg::cmd_t op, input logic [15:0] a,
                                input logic [15:0] b, input logic [2:0] n);
        balu_pkg::alu_out_t pred;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        operand_a    <= a;
        operand_b    <= b;
        bit_or_count <= n;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pred = alu_predict(op, a, b, n, flag_model);
        flag_model = pred.flags;
        predicted_results.push_back(pred);
    endtask

    // hold off new requests until every predicted result has come back
    task automatic pause_until_drained;
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin : result_check
        balu_pkg::alu_out_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %04h flags %02h", result,
                                          flags_out));
            end
            else
            begin
                want = predicted_results.pop_front();
                if (result !== want.res)
                    report_mismatch($sformatf("result expected %04h got %04h", want.res,
                                              result));
                if (flags_out !== want.flags)
                    report_mismatch($sformatf("flags expected %02h got %02h", want.flags,
                                              flags_out));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** byte_alu_with_flags_unit: FAILED **");
            $finish;
        end
    end

    task automatic test_flag_load;
        // bits 5 and 3 drop out
        send_request(balu_pkg::CMD_LOAD_FLAGS, 16'h0000, 16'hFFFF, 3'd0);
        send_request(balu_pkg::CMD_LOAD_FLAGS, 16'hFFFF, 16'hFF00, 3'd7);
    endtask

    task automatic test_byte_arith;
        // high bytes of byte operands are ignored
        send_request(balu_pkg::CMD_ADD_B, 16'hABFF, 16'hCD01, 3'd0);
        send_request(balu_pkg::CMD_ADC_B, 16'h007F, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_SUB_B, 16'h0080, 16'h0001, 3'd0);
        send_request(balu_pkg::CMD_SBC_B, 16'h0000, 16'h00FF, 3'd0);
        send_request(balu_pkg::CMD_CP, 16'hFF42, 16'h0042, 3'd0);
        send_request(balu_pkg::CMD_NEG, 16'h0080, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_NEG, 16'h0000, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_INC_B, 16'h007F, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_DEC_B, 16'h0080, 16'h0000, 3'd0);
    endtask

    task automatic test_word_arith;
        send_request(balu_pkg::CMD_ADD_W, 16'hFFFF, 16'h0001, 3'd0);
        send_request(balu_pkg::CMD_ADC_W, 16'h7FFF, 16'h0000, 3'd0);
        // carry in set, borrow reaches bit 16: no overflow
        send_request(balu_pkg::CMD_LOAD_FLAGS, 16'h0000, 16'h0001, 3'd0);
        send_request(balu_pkg::CMD_SBC_W, 16'h0000, 16'hFFFF, 3'd0);
        send_request(balu_pkg::CMD_INC_W, 16'hFFFF, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_DEC_W, 16'h0000, 16'h0000, 3'd0);
    endtask

    task automatic test_logic;
        send_request(balu_pkg::CMD_AND, 16'h00F0, 16'h000F, 3'd0);
        send_request(balu_pkg::CMD_OR, 16'h0055, 16'h00AA, 3'd0);
        send_request(balu_pkg::CMD_XOR, 16'h00FF, 16'hFFFF, 3'd0);
    endtask

    task automatic test_shift_rotate;
        // count zero still clears bit 0 on SLA
        send_request(balu_pkg::CMD_SLA, 16'h0081, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_SLL, 16'h00FF, 16'h0000, 3'd7);
        send_request(balu_pkg::CMD_SRA, 16'h0080, 16'h0000, 3'd7);
        send_request(balu_pkg::CMD_SRL, 16'h0001, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RL, 16'h0080, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RLC, 16'h0080, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RL_FULL, 16'h0080, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RLC_FULL, 16'h0000, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RR, 16'h0001, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RRC, 16'h0001, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RR_FULL, 16'h0001, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_RRC_FULL, 16'h00FE, 16'h0000, 3'd0);
    endtask

    task automatic test_bit_ops;
        send_request(balu_pkg::CMD_SET, 16'h0000, 16'h0000, 3'd7);
        send_request(balu_pkg::CMD_RES, 16'h00FF, 16'h0000, 3'd0);
        send_request(balu_pkg::CMD_BIT, 16'h00F7, 16'h0000, 3'd3);
        send_request(balu_pkg::CMD_BIT, 16'h0080, 16'h0000, 3'd7);
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h007F;
            3:       return 16'h0080;
            4:       return 16'h7FFF;
            5:       return 16'h8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_random(input int count);
        balu_pkg::cmd_t op;
        logic [15:0]    a;
        logic [15:0]    b;
        logic [2:0]     n;
        for (int i = 0; i < count; i++)
        begin
            op = balu_pkg::cmd_t'($urandom_range(31));
            a  = pick_operand();
            b  = pick_operand();
            n  = 3'($urandom_range(7));
            send_request(op, a, b, n);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_flag_load();
        test_byte_arith();
        test_word_arith();
        test_logic();
        test_shift_rotate();
        test_bit_ops();
        test_random(400);
        pause_until_drained();

        tx_idle_pct = 46;
        rx_idle_pct = 7;
        test_random(400);
        pause_until_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(400);
        pause_until_drained();

        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("** byte_alu_with_flags_unit: PASSED **");
        else
            $display("** byte_alu_with_flags_unit: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hdl/balu_pkg.sv
hdl/byte_alu_with_flags_unit.sv
dv/tb.sv
